// ===== rtl/core/pfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

  // Field element width and modulus 2^63 - 25
  localparam int unsigned ELEM_W = 63;
  localparam logic [62:0] FIELD_P = 63'h7FFF_FFFF_FFFF_FFE7;

  // Fermat exponent P - 2, walked from bit 61 down (bit 62 seeds the result)
  localparam logic [62:0] INV_EXP = 63'h7FFF_FFFF_FFFF_FFE5;
  localparam int unsigned EXP_STEPS = 62;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_INV = 2'd3
  } cmd_t;

  // Payload that rides alongside each multiplier pipeline
  typedef struct packed {
    cmd_t        cmd;
    logic [62:0] quick;  // add/sub/mul result, held until the output
    logic [62:0] x;      // inverse base
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/pfm_fold.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Maps both signed operands to their residue in [0, P-1] over three stages
module pfm_fold (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  pfm_pkg::cmd_t      in_cmd,
  input  logic [63:0]        raw_a,
  input  logic [63:0]        raw_b,
  output logic               out_valid,
  output pfm_pkg::cmd_t      out_cmd,
  output logic [62:0]        res_a,
  output logic [62:0]        res_b
);

  logic [2:0]          vld_r;
  pfm_pkg::cmd_t       cmd_r [3];
  logic [1:0]          neg1_r, neg2_r;
  logic [63:0]         mag_r [2];
  logic [62:0]         red_r [2];
  logic [62:0]         res_r [2];
  logic [63:0]         raw   [2];

  assign raw[0] = raw_a;
  assign raw[1] = raw_b;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // Magnitude, one reduction by P, then negate modulo P
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r[0] <= in_cmd;
      cmd_r[1] <= cmd_r[0];
      cmd_r[2] <= cmd_r[1];
      neg2_r   <= neg1_r;
      for (int i = 0; i < 2; i++) begin
        neg1_r[i] <= raw[i][63];
        mag_r[i]  <= raw[i][63] ? (~raw[i] + 64'd1) : raw[i];
        red_r[i]  <= (mag_r[i] >= {1'b0, pfm_pkg::FIELD_P}) ?
                     63'(mag_r[i] - {1'b0, pfm_pkg::FIELD_P}) : mag_r[i][62:0];
        res_r[i]  <= (neg2_r[i] && (red_r[i] != '0)) ?
                     (pfm_pkg::FIELD_P - red_r[i]) : red_r[i];
      end
    end
  end

  assign out_valid = vld_r[2];
  assign out_cmd   = cmd_r[2];
  assign res_a     = res_r[0];
  assign res_b     = res_r[1];

endmodule

`default_nettype wire

// ===== rtl/core/pfm_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Five-stage modular multiplier: partial products of 32/31-bit halves, sum,
// two folds with 2^63 = 25 (mod P), final conditional subtract.
module pfm_mulmod (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [62:0]     a,
  input  logic [62:0]     b,
  input  pfm_pkg::side_t  side_in,
  output logic            out_valid,
  output logic [62:0]     p,
  output pfm_pkg::side_t  side_out
);

  logic [4:0]      vld_r;
  pfm_pkg::side_t  side_r [5];
  logic [63:0]     pp00_r;
  logic [62:0]     pp01_r, pp10_r;
  logic [61:0]     pp11_r;
  logic [125:0]    prod_r;
  logic [67:0]     t_r;
  logic [63:0]     u_r;
  logic [62:0]     p_r;

  logic [125:0]    prod_nxt;
  logic [67:0]     t_nxt;
  logic [63:0]     u_nxt;
  logic [62:0]     p_nxt;

  // Combine partial products
  assign prod_nxt = (126'(pp11_r) << 64)
                  + ((126'(pp01_r) + 126'(pp10_r)) << 32)
                  + 126'(pp00_r);

  // First fold: hi*25 + lo, below 26*2^63
  assign t_nxt = (68'(prod_r[125:63]) << 4) + (68'(prod_r[125:63]) << 3)
               + 68'(prod_r[125:63]) + 68'(prod_r[62:0]);

  // Second fold: below 2P
  assign u_nxt = 64'(t_r[67:63]) * 64'd25 + 64'(t_r[62:0]);

  assign p_nxt = (u_r >= {1'b0, pfm_pkg::FIELD_P}) ?
                 63'(u_r - {1'b0, pfm_pkg::FIELD_P}) : u_r[62:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00_r    <= 64'(a[31:0]) * 64'(b[31:0]);
      pp01_r    <= 63'(a[31:0]) * 63'(b[62:32]);
      pp10_r    <= 63'(a[62:32]) * 63'(b[31:0]);
      pp11_r    <= 62'(a[62:32]) * 62'(b[62:32]);
      prod_r    <= prod_nxt;
      t_r       <= t_nxt;
      u_r       <= u_nxt;
      p_r       <= p_nxt;
      side_r[0] <= side_in;
      for (int i = 1; i < 5; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[4];
  assign p         = p_r;
  assign side_out  = side_r[4];

endmodule

`default_nettype wire

// ===== rtl/core/pfm_expstep.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One square-and-multiply step of the exponent chain
module pfm_expstep #(
  parameter bit EBIT = 1'b1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [62:0]     res_in,
  input  pfm_pkg::side_t  side_in,
  output logic            out_valid,
  output logic [62:0]     res_out,
  output pfm_pkg::side_t  side_out
);

  logic            sq_valid;
  logic [62:0]     sq;
  pfm_pkg::side_t  sq_side;
  logic [62:0]     mult;

  pfm_mulmod u_sq (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .a(res_in), .b(res_in), .side_in(side_in),
    .out_valid(sq_valid), .p(sq), .side_out(sq_side)
  );

  // Multiply by the base where the exponent bit is set, else by one
  assign mult = EBIT ? sq_side.x : 63'd1;

  pfm_mulmod u_mt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_valid),
    .a(sq), .b(mult), .side_in(sq_side),
    .out_valid(out_valid), .p(res_out), .side_out(side_out)
  );

endmodule

`default_nettype wire

// ===== rtl/core/prime_field_modular_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Modular ALU over GF(2^63 - 25): add, subtract, multiply and inverse
// (a^(P-2)) of two signed 64-bit operands, each first taken to its residue.
// Fully pipelined: one transaction enters per cycle unless out_tready stalls
// the pipeline, and every result passes 3 fold stages, 1 add/sub stage, a
// 5-stage multiplier, then 62 square-and-multiply steps of two 5-stage
// multipliers each, the unrolled Fermat exponent chain. Results come out in
// order; out_tready low freezes the whole pipeline, nothing is lost.
module prime_field_modular_alu (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] operand_a, [127:64] operand_b
  input  logic [1:0]   in_tuser,   // [1:0] cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // [62:0] value, [63] zero
);

  localparam int unsigned N = pfm_pkg::EXP_STEPS;

  logic                en;
  logic                fold_valid;
  pfm_pkg::cmd_t       fold_cmd;
  logic [62:0]         fold_a, fold_b;

  logic                as_vld_r;
  pfm_pkg::cmd_t       as_cmd_r;
  logic [62:0]         as_a_r, as_b_r, as_early_r;
  logic [62:0]         early_nxt;
  logic [63:0]         sum, dif;

  pfm_pkg::side_t      m0_side_in, m0_side;
  logic                m0_valid;
  logic [62:0]         m0_p;

  logic                ch_vld  [N+1];
  logic [62:0]         ch_res  [N+1];
  pfm_pkg::side_t      ch_side [N+1];

  // Whole pipeline advances unless a result is stuck at the output
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  pfm_fold u_fold (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_tvalid && in_tready),
    .in_cmd(pfm_pkg::cmd_t'(in_tuser)),
    .raw_a(in_tdata[63:0]), .raw_b(in_tdata[127:64]),
    .out_valid(fold_valid), .out_cmd(fold_cmd),
    .res_a(fold_a), .res_b(fold_b)
  );

  // Modular add / subtract
  assign sum = 64'(fold_a) + 64'(fold_b);
  assign dif = (fold_a >= fold_b) ? (64'(fold_a) - 64'(fold_b))
                                  : (64'(fold_a) + {1'b0, pfm_pkg::FIELD_P} - 64'(fold_b));

  always_comb begin
    case (fold_cmd)
      pfm_pkg::CMD_SUB: early_nxt = dif[62:0];
      default:          early_nxt = (sum >= {1'b0, pfm_pkg::FIELD_P}) ?
                                    63'(sum - {1'b0, pfm_pkg::FIELD_P}) : sum[62:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      as_vld_r <= 1'b0;
    end else if (en) begin
      as_vld_r <= fold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      as_cmd_r   <= fold_cmd;
      as_a_r     <= fold_a;
      as_b_r     <= fold_b;
      as_early_r <= early_nxt;
    end
  end

  // Plain product
  assign m0_side_in = '{cmd: as_cmd_r, quick: as_early_r, x: as_a_r};

  pfm_mulmod u_mul0 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(as_vld_r),
    .a(as_a_r), .b(as_b_r), .side_in(m0_side_in),
    .out_valid(m0_valid), .p(m0_p), .side_out(m0_side)
  );

  // Chain seed: top exponent bit set, so result starts at the base
  assign ch_vld[0]  = m0_valid;
  assign ch_res[0]  = m0_side.x;
  assign ch_side[0] = '{cmd:   m0_side.cmd,
                        quick: (m0_side.cmd == pfm_pkg::CMD_MUL) ? m0_p : m0_side.quick,
                        x:     m0_side.x};

  // Square-and-multiply over exponent bits 61 down to 0
  for (genvar k = 0; k < N; k++) begin : g_step
    pfm_expstep #(.EBIT(pfm_pkg::INV_EXP[N-1-k])) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .in_valid(ch_vld[k]),
      .res_in(ch_res[k]), .side_in(ch_side[k]),
      .out_valid(ch_vld[k+1]), .res_out(ch_res[k+1]), .side_out(ch_side[k+1])
    );
  end

  assign out_tvalid = ch_vld[N];
  assign out_tdata  = {1'b0, (ch_side[N].cmd == pfm_pkg::CMD_INV) ? ch_res[N]
                                                                  : ch_side[N].quick};

  // Checks
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[62:0] < pfm_pkg::FIELD_P))
    else $error("result not reduced");

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    fold_valid |-> (fold_a < pfm_pkg::FIELD_P) && (fold_b < pfm_pkg::FIELD_P))
    else $error("operand not folded to residue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (as_vld_r && !en) |=> as_vld_r && $stable(as_early_r))
    else $error("pipeline item lost during stall");

endmodule

`default_nettype wire
